FILE: rtl/core/spectral_peak_coherence_score_defines.svh
// assertion macros for the coherence score block
`ifndef SPECTRAL_PEAK_COHERENCE_SCORE_DEFINES_SVH
`define SPECTRAL_PEAK_COHERENCE_SCORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SPCS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spcs assertion failed");
`define SPCS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spcs assertion failed");
`else
`define SPCS_ASSERT_IMP(name, ante, cons)
`define SPCS_ASSERT_NEXT(name, ante, cons)
`endif

`endif

FILE: rtl/core/spcs_pkg.sv
package spcs_pkg;

  // fixed field widths
  localparam int OFF_W  = 8;
  localparam int SUM_W  = 25;
  localparam int MUL_W  = 50;
  localparam int THR_W  = 16;
  localparam int INC_W  = 7;
  localparam int CMP_W  = 66;

  // register indexes
  localparam logic [2:0] REG_BAND_START  = 3'd0;
  localparam logic [2:0] REG_BAND_END    = 3'd1;
  localparam logic [2:0] REG_WINDOW      = 3'd2;
  localparam logic [2:0] REG_THR_LOW     = 3'd3;
  localparam logic [2:0] REG_THR_HIGH    = 3'd4;
  localparam logic [2:0] REG_INC_TABLE   = 3'd5;

  // score classes
  localparam logic [1:0] SCORE_ZERO = 2'd0;
  localparam logic [1:0] SCORE_ONE  = 2'd1;
  localparam logic [1:0] SCORE_TWO  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PK_GO, ST_PK_WAIT, ST_PS_GO, ST_PS_WAIT, ST_BL_GO, ST_BL_WAIT,
    ST_AB_GO, ST_AB_WAIT, ST_SQ, ST_SQSV, ST_PRSV, ST_LO_A, ST_LO_B, ST_LO_C,
    ST_HI_A, ST_HI_B, ST_HI_C, ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    SW_PEAK, SW_PSUM, SW_BELOW, SW_ABOVE
  } sweep_kind_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_SQ, OP_SQSV, OP_PRSV, OP_TLO, OP_THI, OP_CMP, OP_FIN
  } op_t;

  typedef struct packed {
    logic        go;
    sweep_kind_t kind;
    op_t         op;
    logic        thr_hi;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic found;
  } status_t;

endpackage

FILE: rtl/core/spectral_peak_coherence_score.sv
// spectral peak coherence score
// input channel: a bin request (in_bin_power, in_last_bin) is taken at a clock
// edge with start high and busy low. bins are stored one per cycle, up to
// MAX_BINS; further bins of the same spectrum are dropped.
// a request with in_last_bin set raises busy and starts processing: a peak
// search sweep over the band (band_end - band_start + 1 reads), then three
// window sum sweeps (peak, below, above, each its bin count). each sweep has
// a start state, then its reads through the registered memory read; then the
// multiply and compare steps (square, square save, product save, low and high
// threshold compare) run on one shared 25x25 multiplier, then the level update.
// out_valid is registered from the level update; with no peak the sums and
// compares are skipped. a bin without in_last_bin is only stored.
// result channel: out_valid pulses for one cycle with the score, previous
// score, level, peak flag and peak index. the receiver cannot stall.
// config channel: cfg_ready is always high; writes are taken at any time
// and should only be issued while the block is idle.
// reset clears the bin count, previous score, level and restores the
// register defaults.
module spectral_peak_coherence_score #(
  parameter int MAX_BINS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_bin_power,
  input  logic        in_last_bin,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_score,
  output logic [1:0]  out_previous_score,
  output logic [15:0] out_level,
  output logic        out_peak_found,
  output logic [7:0]  out_peak_index
);

  `include "spectral_peak_coherence_score_defines.svh"

  spcs_pkg::cmd_t    cmd;
  spcs_pkg::status_t status;
  logic              accept;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // sequencing
  spcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .last_bin (in_last_bin),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  // storage, sweeps and arithmetic
  spcs_datapath #(.MAX_BINS(MAX_BINS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept             (accept),
    .bin_power          (in_bin_power),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_score          (out_score),
    .out_previous_score (out_previous_score),
    .out_level          (out_level),
    .out_peak_found     (out_peak_found),
    .out_peak_index     (out_peak_index)
  );

  // result strobe is a single cycle and follows the end of processing
  `SPCS_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `SPCS_ASSERT_IMP(a_score_range, out_valid, out_score != 2'd3)
  `SPCS_ASSERT_IMP(a_no_peak_zero, out_valid && !out_peak_found,
                   out_score == spcs_pkg::SCORE_ZERO && out_peak_index == 8'd0)
  `SPCS_ASSERT_IMP(a_strobe_idle, out_valid, !busy)

endmodule

FILE: rtl/core/spcs_ctrl.sv
module spcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              last_bin,
  input  spcs_pkg::status_t status,
  output spcs_pkg::cmd_t    cmd,
  output logic              busy
);

  spcs_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spcs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spcs_pkg::ST_IDLE:    if (accept && last_bin) state_nxt = spcs_pkg::ST_PK_GO;
      spcs_pkg::ST_PK_GO:   state_nxt = spcs_pkg::ST_PK_WAIT;
      spcs_pkg::ST_PK_WAIT: if (status.done) begin
        state_nxt = status.found ? spcs_pkg::ST_PS_GO : spcs_pkg::ST_FIN;
      end
      spcs_pkg::ST_PS_GO:   state_nxt = spcs_pkg::ST_PS_WAIT;
      spcs_pkg::ST_PS_WAIT: if (status.done) state_nxt = spcs_pkg::ST_BL_GO;
      spcs_pkg::ST_BL_GO:   state_nxt = spcs_pkg::ST_BL_WAIT;
      spcs_pkg::ST_BL_WAIT: if (status.done) state_nxt = spcs_pkg::ST_AB_GO;
      spcs_pkg::ST_AB_GO:   state_nxt = spcs_pkg::ST_AB_WAIT;
      spcs_pkg::ST_AB_WAIT: if (status.done) state_nxt = spcs_pkg::ST_SQ;
      spcs_pkg::ST_SQ:      state_nxt = spcs_pkg::ST_SQSV;
      spcs_pkg::ST_SQSV:    state_nxt = spcs_pkg::ST_PRSV;
      spcs_pkg::ST_PRSV:    state_nxt = spcs_pkg::ST_LO_A;
      spcs_pkg::ST_LO_A:    state_nxt = spcs_pkg::ST_LO_B;
      spcs_pkg::ST_LO_B:    state_nxt = spcs_pkg::ST_LO_C;
      spcs_pkg::ST_LO_C:    state_nxt = spcs_pkg::ST_HI_A;
      spcs_pkg::ST_HI_A:    state_nxt = spcs_pkg::ST_HI_B;
      spcs_pkg::ST_HI_B:    state_nxt = spcs_pkg::ST_HI_C;
      spcs_pkg::ST_HI_C:    state_nxt = spcs_pkg::ST_FIN;
      spcs_pkg::ST_FIN:     state_nxt = spcs_pkg::ST_IDLE;
      default:              state_nxt = spcs_pkg::ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd.go     = 1'b0;
    cmd.kind   = spcs_pkg::SW_PEAK;
    cmd.op     = spcs_pkg::OP_NONE;
    cmd.thr_hi = 1'b0;
    unique case (state_r)
      spcs_pkg::ST_PK_GO: cmd.go = 1'b1;
      spcs_pkg::ST_PS_GO: begin
        cmd.go   = 1'b1;
        cmd.kind = spcs_pkg::SW_PSUM;
      end
      spcs_pkg::ST_BL_GO: begin
        cmd.go   = 1'b1;
        cmd.kind = spcs_pkg::SW_BELOW;
      end
      spcs_pkg::ST_AB_GO: begin
        cmd.go   = 1'b1;
        cmd.kind = spcs_pkg::SW_ABOVE;
      end
      spcs_pkg::ST_SQ:   cmd.op = spcs_pkg::OP_SQ;
      spcs_pkg::ST_SQSV: cmd.op = spcs_pkg::OP_SQSV;
      spcs_pkg::ST_PRSV: cmd.op = spcs_pkg::OP_PRSV;
      spcs_pkg::ST_LO_A: cmd.op = spcs_pkg::OP_TLO;
      spcs_pkg::ST_LO_B: cmd.op = spcs_pkg::OP_THI;
      spcs_pkg::ST_LO_C: cmd.op = spcs_pkg::OP_CMP;
      spcs_pkg::ST_HI_A: begin
        cmd.op     = spcs_pkg::OP_TLO;
        cmd.thr_hi = 1'b1;
      end
      spcs_pkg::ST_HI_B: begin
        cmd.op     = spcs_pkg::OP_THI;
        cmd.thr_hi = 1'b1;
      end
      spcs_pkg::ST_HI_C: begin
        cmd.op     = spcs_pkg::OP_CMP;
        cmd.thr_hi = 1'b1;
      end
      spcs_pkg::ST_FIN:  cmd.op = spcs_pkg::OP_FIN;
      default: cmd.op = spcs_pkg::OP_NONE;
    endcase
  end

  assign busy = (state_r != spcs_pkg::ST_IDLE);

endmodule

FILE: rtl/core/spcs_datapath.sv
module spcs_datapath #(
  parameter int MAX_BINS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [15:0]       bin_power,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  spcs_pkg::cmd_t    cmd,
  output spcs_pkg::status_t status,
  output logic              out_valid,
  output logic [1:0]        out_score,
  output logic [1:0]        out_previous_score,
  output logic [15:0]       out_level,
  output logic              out_peak_found,
  output logic [7:0]        out_peak_index
);

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CW = $clog2(MAX_BINS + 1);
  localparam int IW = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int SW = spcs_pkg::SUM_W;
  localparam int MW = spcs_pkg::MUL_W;

  typedef logic signed [IW-1:0] idx_t;

  // spectrum memory
  logic [15:0] mem [MAX_BINS];
  logic [15:0] rdata_r;

  // configuration
  logic [7:0]  band_start_r;
  logic [8:0]  band_end_r;
  logic [47:0] window_r;
  logic [15:0] thr_low_r, thr_high_r;
  logic [62:0] inc_table_r;

  // control state
  logic [CW-1:0] cnt_r;
  logic          swp_r, issue_r, p_act_r, p_zero_r;
  idx_t          cur_r, end_r;
  spcs_pkg::sweep_kind_t kind_r;
  logic [1:0]    nf_r;
  logic          found_r;
  logic [1:0]    last_score_r;
  logic [15:0]   level_r;

  // payload state
  logic [15:0]   w1_r, w2_r, best_r;
  logic [8:0]    cen_r, peak_r;
  logic [SW-1:0] psum_r, below_r, above_r;
  logic [MW-1:0] mul_r, sq_r, prod_r, part_r;
  logic          lt_lo_r, lt_hi_r;

  // window fields
  idx_t peak_i, p1, p2, b1, b2, a1, a2, bs_i, be_i, cnt_i;
  idx_t lo, hi;
  logic below_is_psum;
  logic [15:0] v;
  logic done;

  assign peak_i = idx_t'(peak_r);
  assign p1     = idx_t'(window_r[7:0]);
  assign p2     = idx_t'(window_r[15:8]);
  assign b1     = idx_t'(window_r[23:16]);
  assign b2     = idx_t'(window_r[31:24]);
  assign a1     = idx_t'(window_r[39:32]);
  assign a2     = idx_t'(window_r[47:40]);
  assign bs_i   = idx_t'(band_start_r);
  assign be_i   = idx_t'(band_end_r);
  assign cnt_i  = idx_t'(cnt_r);

  assign below_is_psum = (peak_i - b2) <= b1;

  // sweep range per kind
  always_comb begin
    lo = bs_i - idx_t'(1);
    hi = be_i - idx_t'(1);
    unique case (cmd.kind)
      spcs_pkg::SW_PEAK: begin
        lo = bs_i - idx_t'(1);
        hi = be_i - idx_t'(1);
      end
      spcs_pkg::SW_PSUM: begin
        lo = peak_i - p1;
        hi = peak_i + p2;
      end
      spcs_pkg::SW_BELOW: begin
        lo = below_is_psum ? idx_t'(1) : b1 - idx_t'(1);
        hi = below_is_psum ? idx_t'(0) : peak_i - b2;
      end
      spcs_pkg::SW_ABOVE: begin
        lo = peak_i + a1;
        hi = a2 - idx_t'(1);
      end
      default: begin
        lo = idx_t'(1);
        hi = idx_t'(0);
      end
    endcase
  end

  assign done   = swp_r && !issue_r && !p_act_r;
  assign v      = p_zero_r ? 16'd0 : rdata_r;
  assign status = '{done: done, found: found_r};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_start_r <= 8'd1;
      band_end_r   <= 9'd255;
      window_r     <= '0;
      thr_low_r    <= 16'd256;
      thr_high_r   <= 16'd512;
      inc_table_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spcs_pkg::REG_BAND_START: band_start_r <= cfg_data[7:0];
        spcs_pkg::REG_BAND_END:   band_end_r   <= cfg_data[8:0];
        spcs_pkg::REG_WINDOW:     window_r     <= cfg_data[47:0];
        spcs_pkg::REG_THR_LOW:    thr_low_r    <= cfg_data[15:0];
        spcs_pkg::REG_THR_HIGH:   thr_high_r   <= cfg_data[15:0];
        spcs_pkg::REG_INC_TABLE:  inc_table_r  <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  // bin store write and read
  always_ff @(posedge clk) begin
    if (accept && (cnt_r < CW'(MAX_BINS))) begin
      mem[cnt_r[AW-1:0]] <= bin_power;
    end
    if (issue_r) begin
      rdata_r <= mem[cur_r[AW-1:0]];
    end
  end

  // sweep sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swp_r   <= 1'b0;
      issue_r <= 1'b0;
      p_act_r <= 1'b0;
    end else if (cmd.go) begin
      swp_r   <= 1'b1;
      issue_r <= (lo <= hi);
      p_act_r <= 1'b0;
    end else begin
      p_act_r <= issue_r;
      if (issue_r && (cur_r == end_r)) issue_r <= 1'b0;
      if (done) swp_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      cur_r  <= lo;
      end_r  <= hi;
      kind_r <= cmd.kind;
    end else if (issue_r) begin
      cur_r <= cur_r + idx_t'(1);
    end
    p_zero_r <= (cur_r < idx_t'(0)) || (cur_r >= cnt_i);
  end

  // peak search and window sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      nf_r    <= '0;
    end else if (cmd.go) begin
      unique case (cmd.kind)
        spcs_pkg::SW_PEAK: begin
          found_r <= 1'b0;
          nf_r    <= '0;
          best_r  <= '0;
          peak_r  <= '0;
          cen_r   <= {1'b0, band_start_r};
        end
        spcs_pkg::SW_PSUM:  psum_r  <= '0;
        spcs_pkg::SW_BELOW: below_r <= below_is_psum ? psum_r : '0;
        spcs_pkg::SW_ABOVE: above_r <= '0;
        default: ;
      endcase
    end else if (p_act_r) begin
      unique case (kind_r)
        spcs_pkg::SW_PEAK: begin
          if (nf_r == 2'd2) begin
            if ((w1_r > v) && (w1_r > w2_r) && (w1_r > best_r)) begin
              best_r  <= w1_r;
              peak_r  <= cen_r;
              found_r <= 1'b1;
            end
            cen_r <= cen_r + 9'd1;
          end else begin
            nf_r <= nf_r + 2'd1;
          end
          w2_r <= w1_r;
          w1_r <= v;
        end
        spcs_pkg::SW_PSUM:  psum_r  <= psum_r + SW'(v);
        spcs_pkg::SW_BELOW: below_r <= below_r + SW'(v);
        spcs_pkg::SW_ABOVE: above_r <= above_r + SW'(v);
        default: ;
      endcase
    end
  end

  // shared multiplier and threshold compare
  logic [SW-1:0]  ma, mb;
  logic [15:0]    thr;
  logic [spcs_pkg::CMP_W-1:0] rhs, lhs;

  assign thr = cmd.thr_hi ? thr_high_r : thr_low_r;

  always_comb begin
    ma = psum_r;
    mb = psum_r;
    unique case (cmd.op)
      spcs_pkg::OP_SQSV: begin
        ma = below_r;
        mb = above_r;
      end
      spcs_pkg::OP_TLO: begin
        ma = SW'(thr);
        mb = prod_r[SW-1:0];
      end
      spcs_pkg::OP_THI: begin
        ma = SW'(thr);
        mb = prod_r[MW-1:SW];
      end
      default: begin
        ma = psum_r;
        mb = psum_r;
      end
    endcase
  end

  assign rhs = {mul_r[MW-SW+15:0], {SW{1'b0}}} + spcs_pkg::CMP_W'(part_r);
  assign lhs = spcs_pkg::CMP_W'({sq_r, 8'd0});

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      spcs_pkg::OP_SQ:   mul_r <= ma * mb;
      spcs_pkg::OP_SQSV: begin
        sq_r  <= mul_r;
        mul_r <= ma * mb;
      end
      spcs_pkg::OP_PRSV: prod_r <= mul_r;
      spcs_pkg::OP_TLO:  mul_r <= ma * mb;
      spcs_pkg::OP_THI: begin
        part_r <= mul_r;
        mul_r  <= ma * mb;
      end
      spcs_pkg::OP_CMP: begin
        if (cmd.thr_hi) lt_hi_r <= (lhs < rhs);
        else            lt_lo_r <= (lhs < rhs);
      end
      default: ;
    endcase
  end

  // class, level update and result register
  logic [1:0]  score;
  logic [3:0]  k;
  logic [62:0] inc_sh;
  logic [6:0]  raw;
  logic signed [17:0] lvl_sum;
  logic [15:0] lvl;

  always_comb begin
    if (!found_r)     score = spcs_pkg::SCORE_ZERO;
    else if (lt_lo_r) score = spcs_pkg::SCORE_ZERO;
    else if (lt_hi_r) score = spcs_pkg::SCORE_ONE;
    else              score = spcs_pkg::SCORE_TWO;
    k       = ({2'b00, last_score_r} << 1) + {2'b00, last_score_r} + {2'b00, score};
    inc_sh  = inc_table_r >> (7 * k);
    raw     = inc_sh[6:0];
    lvl_sum = $signed({2'b00, level_r}) + $signed({{11{raw[6]}}, raw});
    if (lvl_sum < 18'sd0)          lvl = 16'd0;
    else if (lvl_sum > 18'sd65535) lvl = 16'hFFFF;
    else                           lvl = lvl_sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      last_score_r <= spcs_pkg::SCORE_ZERO;
      level_r      <= '0;
      out_valid    <= 1'b0;
    end else begin
      out_valid <= (cmd.op == spcs_pkg::OP_FIN);
      if (cmd.op == spcs_pkg::OP_FIN) begin
        cnt_r        <= '0;
        last_score_r <= score;
        level_r      <= lvl;
      end else if (accept && (cnt_r < CW'(MAX_BINS))) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == spcs_pkg::OP_FIN) begin
      out_score          <= score;
      out_previous_score <= last_score_r;
      out_level          <= lvl;
      out_peak_found     <= found_r;
      out_peak_index     <= found_r ? peak_r[7:0] : 8'd0;
    end
  end

endmodule
